[src/cfbl_pkg.sv]
// shared types and constants for the chained free-block list
// no dependencies
package cfbl_pkg;

  localparam int BLOCK_W = 8;

  localparam logic KIND_FREE  = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MARK   = 6'b000010,
    ST_SPILL  = 6'b000100,
    ST_POP    = 6'b001000,
    ST_REFILL = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

endpackage

[src/cfbl_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module cfbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 124
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/chained_free_block_list.sv]
// chained free-block list: free pushes a block, allocate pops one
// free: the result is set in the accepting state; the first free into an empty list first
// writes the end-of-chain marker, and a free into a full list first spills it to the spill ram
// allocate: the result is set in the pop state, or at once for an empty list; a refill copies
// a spilled list back, one free-list ram access per cycle; one request in flight at a time
// depends on cfbl_pkg and cfbl_ram; sync reset clears count and control, rams undefined
module chained_free_block_list
  import cfbl_pkg::*;
#(
  parameter int LIST_DEPTH = 124,
  parameter int NUM_BLOCKS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               kind,
  input  logic [BLOCK_W-1:0] block,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [BLOCK_W-1:0] granted_block,
  output logic               status
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = $clog2(LIST_DEPTH);
  localparam int SPILL_BLOCKS = (NUM_BLOCKS < (1 << BLOCK_W)) ? NUM_BLOCKS : (1 << BLOCK_W);
  localparam int SPILL_DEPTH = SPILL_BLOCKS * LIST_DEPTH;
  localparam int SA = $clog2(SPILL_DEPTH);
  localparam int PW = BLOCK_W + CW;
  localparam logic [CW-1:0] COUNT_FULL = CW'(LIST_DEPTH);
  localparam logic [IW-1:0] IDX_LAST = IW'(LIST_DEPTH - 1);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] idx, idx_next;
  logic [SA-1:0] base, base_next;
  logic [BLOCK_W-1:0] req_block, req_block_next;
  logic [BLOCK_W-1:0] res_block;
  logic res_status;

  logic done;
  logic [BLOCK_W-1:0] done_block;
  logic done_status;
  logic slot_free;
  logic accept;
  logic [CW-1:0] count_m1;
  logic blk_ok;
  logic pop_in_range;
  logic [PW-1:0] prod_in, prod_pop;

  logic fl_we;
  logic [IW-1:0] fl_waddr, fl_raddr;
  logic [BLOCK_W-1:0] fl_wdata, fl_rdata;
  logic sp_we;
  logic [SA-1:0] sp_waddr, sp_raddr;
  logic [BLOCK_W-1:0] sp_wdata, sp_rdata;

  cfbl_ram #(.WIDTH(BLOCK_W), .DEPTH(LIST_DEPTH)) u_list_ram (
    .clk  (clk),
    .we   (fl_we),
    .waddr(fl_waddr),
    .wdata(fl_wdata),
    .raddr(fl_raddr),
    .rdata(fl_rdata)
  );

  cfbl_ram #(.WIDTH(BLOCK_W), .DEPTH(SPILL_DEPTH)) u_spill_ram (
    .clk  (clk),
    .we   (sp_we),
    .waddr(sp_waddr),
    .wdata(sp_wdata),
    .raddr(sp_raddr),
    .rdata(sp_rdata)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign count_m1 = count - CW'(1);
  assign blk_ok = (block != '0) && (32'(block) < NUM_BLOCKS);
  assign pop_in_range = 32'(fl_rdata) < NUM_BLOCKS;
  assign prod_in = PW'(block) * PW'(LIST_DEPTH);
  assign prod_pop = PW'(fl_rdata) * PW'(LIST_DEPTH);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next = idx;
    base_next = base;
    req_block_next = req_block;
    done = 1'b0;
    done_block = '0;
    done_status = STATUS_OK;
    fl_we = 1'b0;
    fl_waddr = '0;
    fl_wdata = '0;
    fl_raddr = '0;
    sp_we = 1'b0;
    sp_waddr = '0;
    sp_wdata = '0;
    sp_raddr = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind == KIND_FREE) begin
            if (!blk_ok) begin
              done = 1'b1;
            end else if (count == '0) begin
              // end-of-chain marker first
              fl_we = 1'b1;
              fl_waddr = '0;
              fl_wdata = '0;
              req_block_next = block;
              state_next = ST_MARK;
            end else if (count == COUNT_FULL) begin
              fl_raddr = '0;
              idx_next = '0;
              base_next = SA'(prod_in);
              req_block_next = block;
              state_next = ST_SPILL;
            end else begin
              fl_we = 1'b1;
              fl_waddr = count[IW-1:0];
              fl_wdata = block;
              count_next = count + CW'(1);
              done = 1'b1;
            end
          end else begin
            if (count == '0) begin
              done = 1'b1;
              done_status = STATUS_EMPTY;
            end else begin
              fl_raddr = count_m1[IW-1:0];
              state_next = ST_POP;
            end
          end
        end
      end
      ST_MARK: begin
        fl_we = 1'b1;
        fl_waddr = IW'(1);
        fl_wdata = req_block;
        count_next = CW'(2);
        done = 1'b1;
      end
      ST_SPILL: begin
        sp_we = 1'b1;
        sp_waddr = base + SA'(idx);
        sp_wdata = fl_rdata;
        if (idx == IDX_LAST) begin
          fl_we = 1'b1;
          fl_waddr = '0;
          fl_wdata = req_block;
          count_next = CW'(1);
          done = 1'b1;
        end else begin
          fl_raddr = IW'(idx + IW'(1));
          idx_next = IW'(idx + IW'(1));
        end
      end
      ST_POP: begin
        if (fl_rdata == '0) begin
          done = 1'b1;
          done_status = STATUS_EMPTY;
        end else if (count == CW'(1) && pop_in_range) begin
          sp_raddr = SA'(prod_pop);
          base_next = SA'(prod_pop);
          idx_next = '0;
          req_block_next = fl_rdata;
          state_next = ST_REFILL;
        end else begin
          count_next = count_m1;
          done = 1'b1;
          done_block = fl_rdata;
        end
      end
      ST_REFILL: begin
        fl_we = 1'b1;
        fl_waddr = idx;
        fl_wdata = sp_rdata;
        if (idx == IDX_LAST) begin
          count_next = COUNT_FULL;
          done = 1'b1;
          done_block = req_block;
        end else begin
          sp_raddr = base + SA'(IW'(idx + IW'(1)));
          idx_next = IW'(idx + IW'(1));
        end
      end
      ST_FINISH: begin
        done = 1'b1;
        done_block = res_block;
        done_status = res_status;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (done) begin
      state_next = slot_free ? ST_IDLE : ST_FINISH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (done && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    base <= base_next;
    req_block <= req_block_next;
    if (done) begin
      res_block <= done_block;
      res_status <= done_status;
    end
    if (done && slot_free) begin
      granted_block <= done_block;
      status <= done_status;
    end
  end

endmodule

[test/chained_free_block_list_test.sv]
// self-checking bench for the chained free-block list: free and allocate requests
// are predicted against a local copy of the list and spill store, results checked in order
// depends on cfbl_pkg and chained_free_block_list
`timescale 1ns / 100ps

module chained_free_block_list_test;
  import cfbl_pkg::*;

  localparam int LIST_DEPTH = 124;
  localparam int NUM_BLOCKS = 256;
  localparam int ITEMS      = 1650;

  typedef struct packed {
    logic               kind;
    logic [BLOCK_W-1:0] block;
  } request_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] granted;
    logic               status;
  } grant_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               req_valid     = 1'b0;
  logic               kind          = KIND_FREE;
  logic [BLOCK_W-1:0] block         = '0;
  logic               rsp_ready     = 1'b0;
  logic               req_ready;
  logic               rsp_valid;
  logic [BLOCK_W-1:0] granted_block;
  logic               status;

  request_t pending[$];
  grant_t   grants_due[$];
  request_t next_req;
  grant_t   want;

  // local copy of the block's state
  logic [BLOCK_W-1:0] list_mem [LIST_DEPTH];
  int unsigned        list_fill;
  logic [BLOCK_W-1:0] spill_mem [NUM_BLOCKS*LIST_DEPTH];

  int sent_count   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int spills       = 0;
  int refills      = 0;
  int empties      = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  logic calm;

  chained_free_block_list #(
    .LIST_DEPTH(LIST_DEPTH),
    .NUM_BLOCKS(NUM_BLOCKS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .kind(kind),
    .block(block),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .granted_block(granted_block),
    .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  assign calm = (sent_count >= 500) && (sent_count < 800);

  task automatic report_mismatch(input string what);
    if (mismatches < 50) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatches++;
  endtask

  task automatic predict_grant(input logic k, input logic [BLOCK_W-1:0] b);
    grant_t r;
    int     top;
    int     base;
    r.granted = '0;
    r.status  = STATUS_OK;
    if (k == KIND_FREE) begin
      if (b != 0 && int'(b) < NUM_BLOCKS) begin
        if (list_fill == 0) begin
          list_mem[0] = '0;
          list_fill   = 1;
        end
        if (list_fill >= LIST_DEPTH) begin
          base = int'(b) * LIST_DEPTH;
          for (int i = 0; i < LIST_DEPTH; i++) spill_mem[base + i] = list_mem[i];
          list_fill = 0;
          spills++;
        end
        list_mem[list_fill] = b;
        list_fill++;
      end
    end else if (list_fill == 0) begin
      r.status = STATUS_EMPTY;
      empties++;
    end else begin
      top = int'(list_mem[list_fill - 1]);
      if (top == 0) begin
        // end of chain: the marker stays put
        r.status = STATUS_EMPTY;
        empties++;
      end else begin
        list_fill--;
        if (list_fill == 0 && top < NUM_BLOCKS) begin
          base = top * LIST_DEPTH;
          for (int i = 0; i < LIST_DEPTH; i++) list_mem[i] = spill_mem[base + i];
          list_fill = LIST_DEPTH;
          refills++;
        end
        r.granted = BLOCK_W'(top);
      end
    end
    grants_due.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        predict_grant(kind, block);
        sent_count <= sent_count + 1;
      end
      if ((!req_valid || req_ready) && pending.size() > 0 &&
          (calm || $urandom_range(99) >= 30)) begin
        next_req = pending.pop_front();
        req_valid <= 1'b1;
        kind      <= next_req.kind;
        block     <= next_req.block;
      end else if (req_valid && req_ready) begin
        req_valid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && sent_count >= 1000) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 30);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen <= results_seen + 1;
      if (grants_due.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding");
      end else begin
        want = grants_due.pop_front();
        if (granted_block !== want.granted) begin
          report_mismatch($sformatf("granted_block %0d, expected %0d",
                                    granted_block, want.granted));
        end
        if (status !== want.status) begin
          report_mismatch($sformatf("status %0b, expected %0b", status, want.status));
        end
      end
    end
  end

  initial begin
    int pick;
    int run;
    int total;
    list_fill = 0;

    // directed: empty list, ignored frees, extremes, end-of-chain marker
    pending.push_back('{KIND_ALLOC, 8'h00});
    pending.push_back('{KIND_FREE,  8'h00});
    pending.push_back('{KIND_ALLOC, 8'hff});
    pending.push_back('{KIND_FREE,  8'hff});
    pending.push_back('{KIND_FREE,  8'h01});
    pending.push_back('{KIND_FREE,  8'h80});
    pending.push_back('{KIND_FREE,  8'h00});
    pending.push_back('{KIND_FREE,  8'hff});
    pending.push_back('{KIND_ALLOC, 8'h5a});
    pending.push_back('{KIND_ALLOC, 8'h00});
    pending.push_back('{KIND_ALLOC, 8'hff});
    pending.push_back('{KIND_ALLOC, 8'ha5});
    pending.push_back('{KIND_ALLOC, 8'h00});
    pending.push_back('{KIND_ALLOC, 8'h00});
    pending.push_back('{KIND_FREE,  8'haa});
    pending.push_back('{KIND_FREE,  8'h55});
    pending.push_back('{KIND_ALLOC, 8'h00});
    pending.push_back('{KIND_ALLOC, 8'h00});
    pending.push_back('{KIND_ALLOC, 8'h00});

    // random: mostly fill-then-drain bursts to force spills and refills, some noise
    while (pending.size() < ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run = $urandom_range(300, 1);
        repeat (run) begin
          if ($urandom_range(19) == 0) begin
            pending.push_back('{KIND_FREE, 8'($urandom_range(255))});
          end else begin
            pending.push_back('{KIND_FREE, 8'($urandom_range(255, 1))});
          end
        end
        run = $urandom_range(320, 1);
        repeat (run) pending.push_back('{KIND_ALLOC, 8'($urandom)});
      end else begin
        run = $urandom_range(40, 1);
        repeat (run) pending.push_back('{1'($urandom), 8'($urandom)});
      end
    end
    while (pending.size() > ITEMS) pending.delete(pending.size() - 1);
    total = pending.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (results_seen < total) @(posedge clk);
    repeat (LIST_DEPTH + 20) @(posedge clk);

    $display("%0d requests, %0d results checked, %0d mismatches", sent_count,
             results_seen, mismatches);
    $display("%0d spills, %0d refills, %0d empty answers", spills, refills, empties);
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("chained_free_block_list_test passed");
    end else begin
      $display("chained_free_block_list_test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", grants_due.size());
    $display("chained_free_block_list_test failed");
    $finish;
  end

endmodule
